### src/ycb_pkg.sv
// Shared constants, types and helpers for the YCbCr color blend pipeline.
// No dependencies; imported by ycb_fwd, ycbcr_color_blend_top and the testbench.
package ycb_pkg;

  localparam int CHANNEL_BITS   = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PORT_W         = 16;
  localparam int FACTOR_W       = 10;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd461;

  // coefficient numerators in units of 1e-5
  localparam longint K_YR_N  = 29900;
  localparam longint K_YG_N  = 58700;
  localparam longint K_YB_N  = 11400;
  localparam longint K_CBR_N = 16870;
  localparam longint K_CBG_N = 33130;
  localparam longint K_CBB_N = 50000;
  localparam longint K_CRR_N = 50000;
  localparam longint K_CRG_N = 41870;
  localparam longint K_CRB_N = 8130;
  localparam longint K_RCR_N = 140200;
  localparam longint K_GCB_N = 34414;
  localparam longint K_GCR_N = 71414;
  localparam longint K_BCB_N = 177200;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } ycb_adv_t;

  function automatic longint coef_q(input longint num, input int frac);
    return (num * (longint'(1) << frac) + 64'sd50000) / 64'sd100000;
  endfunction

  // width of one color's signed Y, Cb or Cr
  function automatic int fwd_w(input int cb, input int frac);
    return cb + frac + 3;
  endfunction

endpackage

### src/ycb_fwd.sv
// RGB to YCbCr forward transform for one color: product stage, then sum stage.
// Depends on ycb_pkg for coefficients, the width helper and the advance struct.
module ycb_fwd import ycb_pkg::*; #(
  parameter int P_CB = CHANNEL_BITS,
  parameter int P_F  = COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  ycb_adv_t                            adv,
  input  logic [P_CB-1:0]                     red,
  input  logic [P_CB-1:0]                     green,
  input  logic [P_CB-1:0]                     blue,
  output logic signed [fwd_w(P_CB, P_F)-1:0]  y_r,
  output logic signed [fwd_w(P_CB, P_F)-1:0]  cb_r,
  output logic signed [fwd_w(P_CB, P_F)-1:0]  cr_r
);

  localparam int YW = fwd_w(P_CB, P_F);
  localparam int PW = P_CB + P_F;

  localparam logic [P_F-1:0] K_YR  = P_F'(coef_q(K_YR_N, P_F));
  localparam logic [P_F-1:0] K_YG  = P_F'(coef_q(K_YG_N, P_F));
  localparam logic [P_F-1:0] K_YB  = P_F'(coef_q(K_YB_N, P_F));
  localparam logic [P_F-1:0] K_CBR = P_F'(coef_q(K_CBR_N, P_F));
  localparam logic [P_F-1:0] K_CBG = P_F'(coef_q(K_CBG_N, P_F));
  localparam logic [P_F-1:0] K_CBB = P_F'(coef_q(K_CBB_N, P_F));
  localparam logic [P_F-1:0] K_CRR = P_F'(coef_q(K_CRR_N, P_F));
  localparam logic [P_F-1:0] K_CRG = P_F'(coef_q(K_CRG_N, P_F));
  localparam logic [P_F-1:0] K_CRB = P_F'(coef_q(K_CRB_N, P_F));

  logic [PW-1:0] p_yr_r, p_yg_r, p_yb_r;
  logic [PW-1:0] p_cbr_r, p_cbg_r, p_cbb_r;
  logic [PW-1:0] p_crr_r, p_crg_r, p_crb_r;
  logic signed [YW-1:0] y_nxt, cb_nxt, cr_nxt;

  always_ff @(posedge clk) begin
    if (adv.prod_en) begin
      p_yr_r  <= PW'(red)   * PW'(K_YR);
      p_yg_r  <= PW'(green) * PW'(K_YG);
      p_yb_r  <= PW'(blue)  * PW'(K_YB);
      p_cbr_r <= PW'(red)   * PW'(K_CBR);
      p_cbg_r <= PW'(green) * PW'(K_CBG);
      p_cbb_r <= PW'(blue)  * PW'(K_CBB);
      p_crr_r <= PW'(red)   * PW'(K_CRR);
      p_crg_r <= PW'(green) * PW'(K_CRG);
      p_crb_r <= PW'(blue)  * PW'(K_CRB);
    end
  end

  always_comb begin
    y_nxt  = $signed(YW'(p_yr_r) + YW'(p_yg_r) + YW'(p_yb_r));
    cb_nxt = $signed(YW'(p_cbb_r) - YW'(p_cbr_r) - YW'(p_cbg_r));
    cr_nxt = $signed(YW'(p_crr_r) - YW'(p_crg_r) - YW'(p_crb_r));
  end

  always_ff @(posedge clk) begin
    if (adv.sum_en) begin
      y_r  <= y_nxt;
      cb_r <= cb_nxt;
      cr_r <= cr_nxt;
    end
  end

endmodule

### src/ycbcr_color_blend_top.sv
// YCbCr color blend: six-stage pipeline, one transaction per cycle sustained unless the output stalls.
// An accepted transaction's valid bit moves from vld_r[0] through vld_r[5], which is out_valid.
// Throughput: one color pair per clock; a stage holds only when it and all later stages are full and out_ready is low.
// Stages: forward products, forward sums, blend products, blend sums,
// inverse products, round and saturate into the output register.
// Reset (rst_n low, synchronous) empties the pipeline and sets blend_factor to 461.
module ycbcr_color_blend_top import ycb_pkg::*; #(
  parameter int CHANNEL_BITS   = ycb_pkg::CHANNEL_BITS,
  parameter int COEF_FRAC_BITS = ycb_pkg::COEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FACTOR_W-1:0] cfg_blend_factor,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PORT_W-1:0]   in_fg_red,
  input  logic [PORT_W-1:0]   in_fg_green,
  input  logic [PORT_W-1:0]   in_fg_blue,
  input  logic [PORT_W-1:0]   in_fg_alpha,
  input  logic [PORT_W-1:0]   in_bg_red,
  input  logic [PORT_W-1:0]   in_bg_green,
  input  logic [PORT_W-1:0]   in_bg_blue,
  input  logic [PORT_W-1:0]   in_bg_alpha,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PORT_W-1:0]   out_red,
  output logic [PORT_W-1:0]   out_green,
  output logic [PORT_W-1:0]   out_blue,
  output logic [PORT_W-1:0]   out_alpha
);

  localparam int P_CB = CHANNEL_BITS;
  localparam int P_F  = COEF_FRAC_BITS;
  localparam int NSTG = 6;
  localparam int YW   = fwd_w(P_CB, P_F);
  localparam int WW   = FACTOR_W + 1;
  localparam int MW   = YW + WW;
  localparam int BW   = MW + 1 - 8;
  localparam int KW   = P_F + 2;
  localparam int IW   = BW + KW;
  localparam int SW   = IW + 2;
  localparam int AW   = P_CB + 1 + WW;
  localparam int ASW  = AW + 1 - 8;

  localparam logic signed [KW-1:0] K_RCR = KW'(coef_q(K_RCR_N, P_F));
  localparam logic signed [KW-1:0] K_GCB = KW'(coef_q(K_GCB_N, P_F));
  localparam logic signed [KW-1:0] K_GCR = KW'(coef_q(K_GCR_N, P_F));
  localparam logic signed [KW-1:0] K_BCB = KW'(coef_q(K_BCB_N, P_F));

  localparam logic signed [MW:0]   RND_M   = (MW+1)'(128);
  localparam logic signed [AW:0]   RND_A   = (AW+1)'(128);
  localparam logic signed [SW-1:0] HALF_S  = SW'(longint'(1) << (2*P_F - 1));
  localparam logic signed [SW-1:0] CHMAX_S = SW'((longint'(1) << P_CB) - 1);
  localparam logic signed [ASW-1:0] CHMAX_A = ASW'((longint'(1) << P_CB) - 1);
  localparam logic signed [WW-1:0] W_ONE   = WW'(256);

  logic [FACTOR_W-1:0] fct_r;
  logic [NSTG-1:0]     vld_r;
  logic [NSTG-1:0]     adv;
  ycb_adv_t            fwd_adv;

  logic signed [YW-1:0] fy_r, fcb_r, fcr_r, by_r, bcb_r, bcr_r;
  logic [P_CB-1:0]      fa0_r, ba0_r, fa1_r, ba1_r;

  logic signed [WW-1:0] w_fg, w_bg;
  logic signed [MW-1:0] pm_fy_r, pm_by_r, pm_fcb_r, pm_bcb_r, pm_fcr_r, pm_bcr_r;
  logic signed [AW-1:0] pa_f_r, pa_b_r;

  logic signed [MW:0]   sm_y, sm_cb, sm_cr;
  logic signed [AW:0]   sa;
  logic signed [ASW-1:0] a_mix;
  logic signed [BW-1:0] y3_r, cb3_r, cr3_r;
  logic [P_CB-1:0]      a3_nxt, a3_r, a4_r;

  logic signed [IW-1:0] p_rcr_r, p_gcb_r, p_gcr_r, p_bcb_r;
  logic signed [BW-1:0] y4_r;

  logic signed [SW-1:0] s_r, s_g, s_b;
  logic [P_CB-1:0]      red_nxt, green_nxt, blue_nxt;
  logic [P_CB-1:0]      red_r, green_r, blue_r, alpha_r;

  function automatic logic [P_CB-1:0] sat_ch(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v >>> (2 * P_F);
    if (t < 0) begin
      return '0;
    end else if (t > CHMAX_S) begin
      return '1;
    end
    return t[P_CB-1:0];
  endfunction

  // handshake and stage advance
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign cfg_ready = 1'b1;
  assign fwd_adv   = '{prod_en: adv[0], sum_en: adv[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fct_r <= FACTOR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fct_r <= cfg_blend_factor;
      end
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stages 0 and 1: forward transforms
  ycb_fwd #(.P_CB(P_CB), .P_F(P_F)) u_fwd_fg (
    .clk   (clk),
    .adv   (fwd_adv),
    .red   (in_fg_red[P_CB-1:0]),
    .green (in_fg_green[P_CB-1:0]),
    .blue  (in_fg_blue[P_CB-1:0]),
    .y_r   (fy_r),
    .cb_r  (fcb_r),
    .cr_r  (fcr_r)
  );

  ycb_fwd #(.P_CB(P_CB), .P_F(P_F)) u_fwd_bg (
    .clk   (clk),
    .adv   (fwd_adv),
    .red   (in_bg_red[P_CB-1:0]),
    .green (in_bg_green[P_CB-1:0]),
    .blue  (in_bg_blue[P_CB-1:0]),
    .y_r   (by_r),
    .cb_r  (bcb_r),
    .cr_r  (bcr_r)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fa0_r <= in_fg_alpha[P_CB-1:0];
      ba0_r <= in_bg_alpha[P_CB-1:0];
    end
    if (adv[1]) begin
      fa1_r <= fa0_r;
      ba1_r <= ba0_r;
    end
  end

  // stage 2: blend products
  assign w_fg = $signed({1'b0, fct_r});
  assign w_bg = W_ONE - w_fg;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pm_fy_r  <= MW'(fy_r)  * MW'(w_fg);
      pm_by_r  <= MW'(by_r)  * MW'(w_bg);
      pm_fcb_r <= MW'(fcb_r) * MW'(w_fg);
      pm_bcb_r <= MW'(bcb_r) * MW'(w_bg);
      pm_fcr_r <= MW'(fcr_r) * MW'(w_fg);
      pm_bcr_r <= MW'(bcr_r) * MW'(w_bg);
      pa_f_r   <= AW'($signed({1'b0, fa1_r})) * AW'(w_fg);
      pa_b_r   <= AW'($signed({1'b0, ba1_r})) * AW'(w_bg);
    end
  end

  // stage 3: blend sums, round, alpha saturate
  always_comb begin
    sm_y  = (MW+1)'(pm_fy_r)  + (MW+1)'(pm_by_r)  + RND_M;
    sm_cb = (MW+1)'(pm_fcb_r) + (MW+1)'(pm_bcb_r) + RND_M;
    sm_cr = (MW+1)'(pm_fcr_r) + (MW+1)'(pm_bcr_r) + RND_M;
    sa    = (AW+1)'(pa_f_r) + (AW+1)'(pa_b_r) + RND_A;
    a_mix = ASW'(sa >>> 8);
    if (a_mix < 0) begin
      a3_nxt = '0;
    end else if (a_mix > CHMAX_A) begin
      a3_nxt = '1;
    end else begin
      a3_nxt = a_mix[P_CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      y3_r  <= BW'(sm_y  >>> 8);
      cb3_r <= BW'(sm_cb >>> 8);
      cr3_r <= BW'(sm_cr >>> 8);
      a3_r  <= a3_nxt;
    end
  end

  // stage 4: inverse products
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      p_rcr_r <= IW'(cr3_r) * IW'(K_RCR);
      p_gcb_r <= IW'(cb3_r) * IW'(K_GCB);
      p_gcr_r <= IW'(cr3_r) * IW'(K_GCR);
      p_bcb_r <= IW'(cb3_r) * IW'(K_BCB);
      y4_r    <= y3_r;
      a4_r    <= a3_r;
    end
  end

  // stage 5: sums, round half up, saturate
  always_comb begin
    s_r = (SW'(y4_r) <<< P_F) + SW'(p_rcr_r) + HALF_S;
    s_g = (SW'(y4_r) <<< P_F) - SW'(p_gcb_r) - SW'(p_gcr_r) + HALF_S;
    s_b = (SW'(y4_r) <<< P_F) + SW'(p_bcb_r) + HALF_S;
    red_nxt   = sat_ch(s_r);
    green_nxt = sat_ch(s_g);
    blue_nxt  = sat_ch(s_b);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= a4_r;
    end
  end

  assign out_red   = PORT_W'(red_r);
  assign out_green = PORT_W'(green_r);
  assign out_blue  = PORT_W'(blue_r);
  assign out_alpha = PORT_W'(alpha_r);

  a_cfg_reset: assert property (@(posedge clk) !rst_n |=> fct_r == FACTOR_RESET)
    else $error("blend factor not restored by reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transaction missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && !adv[2] |=> vld_r[2] && vld_r[3])
    else $error("stalled blend stage dropped a transaction");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NSTG-2]))
    else $error("output became valid without a transaction behind it");

endmodule

### tb/tb_ycbcr_color_blend_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ycbcr_color_blend_top: directed and random color pairs
// against an in-bench fixed-point BT.601 blend predictor. Depends on ycb_pkg.
module tb_ycbcr_color_blend_top import ycb_pkg::*; ();

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PAIRS = 80;

  typedef struct packed {
    logic [PORT_W-1:0] fg_red;
    logic [PORT_W-1:0] fg_green;
    logic [PORT_W-1:0] fg_blue;
    logic [PORT_W-1:0] fg_alpha;
    logic [PORT_W-1:0] bg_red;
    logic [PORT_W-1:0] bg_green;
    logic [PORT_W-1:0] bg_blue;
    logic [PORT_W-1:0] bg_alpha;
  } color_pair_t;

  typedef struct packed {
    logic [PORT_W-1:0] red;
    logic [PORT_W-1:0] green;
    logic [PORT_W-1:0] blue;
    logic [PORT_W-1:0] alpha;
  } rgba_t;

  class blend_scoreboard;
    logic [FACTOR_W-1:0] factor;
    rgba_t pending_colors[$];
    int mismatches;
    longint y_r, y_g, y_b, cb_r, cb_g, cb_b, cr_r, cr_g, cr_b;
    longint r_cr, g_cb, g_cr, b_cb;

    function new();
      factor = FACTOR_RESET;
      mismatches = 0;
      y_r = to_fixed(29900);
      y_g = to_fixed(58700);
      y_b = to_fixed(11400);
      cb_r = to_fixed(16870);
      cb_g = to_fixed(33130);
      cb_b = to_fixed(50000);
      cr_r = to_fixed(50000);
      cr_g = to_fixed(41870);
      cr_b = to_fixed(8130);
      r_cr = to_fixed(140200);
      g_cb = to_fixed(34414);
      g_cr = to_fixed(71414);
      b_cb = to_fixed(177200);
    endfunction

    // numerator in units of 1e-5, rounded to Q1.COEF_FRAC_BITS
    function longint to_fixed(longint num);
      return (num * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;
    endfunction

    function longint weigh(longint f, longint a, longint b);
      return (f * a + (256 - f) * b + 128) >>> 8;
    endfunction

    function logic [PORT_W-1:0] clamp_channel(longint v);
      longint top;
      top = (longint'(1) << CHANNEL_BITS) - 1;
      if (v < 0) return '0;
      if (v > top) return top[PORT_W-1:0];
      return v[PORT_W-1:0];
    endfunction

    function logic [PORT_W-1:0] round_channel(longint q);
      longint half;
      half = longint'(1) << (2 * COEF_FRAC_BITS - 1);
      return clamp_channel((q + half) >>> (2 * COEF_FRAC_BITS));
    endfunction

    function rgba_t blend_pair(color_pair_t p);
      longint f, fr, fg, fb, fa, br, bgr, bb, ba;
      longint fy, fcb, fcr, by, bcb, bcr, y, cb, cr;
      rgba_t r;
      f = factor;
      fr = p.fg_red;
      fg = p.fg_green;
      fb = p.fg_blue;
      fa = p.fg_alpha;
      br = p.bg_red;
      bgr = p.bg_green;
      bb = p.bg_blue;
      ba = p.bg_alpha;
      fy = y_r * fr + y_g * fg + y_b * fb;
      fcb = -cb_r * fr - cb_g * fg + cb_b * fb;
      fcr = cr_r * fr - cr_g * fg - cr_b * fb;
      by = y_r * br + y_g * bgr + y_b * bb;
      bcb = -cb_r * br - cb_g * bgr + cb_b * bb;
      bcr = cr_r * br - cr_g * bgr - cr_b * bb;
      y = weigh(f, fy, by);
      cb = weigh(f, fcb, bcb);
      cr = weigh(f, fcr, bcr);
      y = y <<< COEF_FRAC_BITS;
      r.red = round_channel(y + r_cr * cr);
      r.green = round_channel(y - g_cb * cb - g_cr * cr);
      r.blue = round_channel(y + b_cb * cb);
      r.alpha = clamp_channel(weigh(f, fa, ba));
      return r;
    endfunction

    function void note_input(color_pair_t p);
      pending_colors.push_back(blend_pair(p));
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected output %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_colors.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        mismatches++;
      end
      if (got.alpha !== want.alpha) begin
        $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [FACTOR_W-1:0] cfg_blend_factor;
  logic in_valid;
  logic in_ready;
  logic [PORT_W-1:0] in_fg_red, in_fg_green, in_fg_blue, in_fg_alpha;
  logic [PORT_W-1:0] in_bg_red, in_bg_green, in_bg_blue, in_bg_alpha;
  logic out_valid;
  logic out_ready;
  logic [PORT_W-1:0] out_red, out_green, out_blue, out_alpha;

  blend_scoreboard sb;
  bit steady;
  int quiet_cycles;

  ycbcr_color_blend_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_blend_factor(cfg_blend_factor),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_fg_red(in_fg_red),
    .in_fg_green(in_fg_green),
    .in_fg_blue(in_fg_blue),
    .in_fg_alpha(in_fg_alpha),
    .in_bg_red(in_bg_red),
    .in_bg_green(in_bg_green),
    .in_bg_blue(in_bg_blue),
    .in_bg_alpha(in_bg_alpha),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_red, out_green, out_blue, out_alpha});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PORT_W-1:0] random_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PORT_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic color_pair_t random_pair();
    color_pair_t p;
    p.fg_red = random_channel();
    p.fg_green = random_channel();
    p.fg_blue = random_channel();
    p.fg_alpha = random_channel();
    p.bg_red = random_channel();
    p.bg_green = random_channel();
    p.bg_blue = random_channel();
    p.bg_alpha = random_channel();
    return p;
  endfunction

  function automatic color_pair_t directed_pair(int k);
    color_pair_t p;
    case (k)
      0: p = '0;
      1: p = '1;
      2: p = {{4{16'hFFFF}}, {4{16'h0000}}};
      3: p = {{4{16'hAAAA}}, {4{16'h5555}}};
      default: p = {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                    16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
    endcase
    return p;
  endfunction

  // enter and leave at a falling edge
  task automatic send_pair(color_pair_t p);
    in_valid <= 1'b1;
    {in_fg_red, in_fg_green, in_fg_blue, in_fg_alpha,
     in_bg_red, in_bg_green, in_bg_blue, in_bg_alpha} <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_input(p);
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_factor(logic [FACTOR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_blend_factor <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.factor = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    for (int k = 0; k < 5; k++) begin
      send_pair(directed_pair(k));
      maybe_idle();
    end
  endtask

  initial begin
    logic [FACTOR_W-1:0] extremes[4];
    logic [FACTOR_W-1:0] f;
    extremes = '{10'd0, 10'd256, 10'd512, 10'd1023};
    sb = new();
    steady = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_blend_factor = '0;
    in_valid = 1'b0;
    {in_fg_red, in_fg_green, in_fg_blue, in_fg_alpha} = '0;
    {in_bg_red, in_bg_green, in_bg_blue, in_bg_alpha} = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    foreach (extremes[i]) begin
      drain();
      write_factor(extremes[i]);
      run_directed();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: f = FACTOR_W'($urandom_range(0, 256));
        1: f = FACTOR_W'($urandom_range(257, 512));
        2: f = FACTOR_W'($urandom_range(513, 1023));
        3: f = 10'd128;
        4: f = 10'd1;
        5: f = 10'd511;
        6: f = FACTOR_W'($urandom_range(0, 1023));
        default: f = FACTOR_W'($urandom_range(0, 512));
      endcase
      write_factor(f);
      steady = (ph == 3);
      repeat (PHASE_PAIRS) begin
        send_pair(random_pair());
        maybe_idle();
      end
    end

    drain();
    steady = 1'b0;
    if (sb.mismatches == 0 && sb.pending_colors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### ycbcr_color_blend_top.f
src/ycb_pkg.sv
src/ycb_fwd.sv
src/ycbcr_color_blend_top.sv
tb/tb_ycbcr_color_blend_top.sv
